[hdl/ictf_pkg.sv]
// shared constants, types and the arctangent table of the tilt filter
package ictf_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ATAN_TABLE_LEN    = 24;
   localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_TABLE_LEN) ?
                                      CORDIC_ITERATIONS : ATAN_TABLE_LEN;
   localparam int ITER_W            = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   localparam int SAMPLE_W = 16;
   localparam int ANGLE_W  = 17;
   localparam int XY_W     = 26;
   localparam int Z_W      = 25;
   localparam int WEIGHT_W = 17;
   localparam int GAIN_W   = 16;
   localparam int MUL_W    = 18;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int SUM_W    = ACC_W - 16;

   localparam logic [WEIGHT_W-1:0]      WEIGHT_ONE   = 17'd65536;
   localparam logic [WEIGHT_W-1:0]      WEIGHT_RESET = 17'd64225;
   localparam logic [GAIN_W-1:0]        GAIN_RESET   = 16'd1280;
   localparam logic signed [Z_W-1:0]    Z_QUARTER    = 25'sd5898240;
   localparam logic signed [Z_W-1:0]    Z_HALF_LSB   = 25'sd128;
   localparam logic signed [PROD_W-1:0] PROD_HALF    = 36'sd32768;
   localparam logic signed [ACC_W-1:0]  ACC_HALF     = 37'sd32768;
   localparam logic signed [SUM_W-1:0]  EST_MAX      = 21'sd65535;
   localparam logic signed [SUM_W-1:0]  EST_MIN      = -21'sd65536;

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_BLEND_WEIGHT = 1'b0;
   localparam logic REG_GYRO_GAIN    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROLL_ATAN,
      ST_PITCH_ATAN,
      ST_ROLL_BLEND,
      ST_PITCH_BLEND,
      ST_DELIVER
   } tilt_state_type;

   typedef enum logic [1:0] {
      BL_RATE,
      BL_PROP,
      BL_ACCEL,
      BL_SUM
   } blend_step_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0]  est;
      logic signed [SAMPLE_W-1:0] gyro;
      logic signed [ANGLE_W-1:0]  accel;
      logic [WEIGHT_W-1:0]        weight;
      logic [GAIN_W-1:0]          gain;
   } blend_opnd_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic signed [Z_W-1:0] atan_step(input logic [4:0] idx);
      logic signed [Z_W-1:0] v;
      begin
         case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = 25'sd0;
         endcase
         return v;
      end
   endfunction

endpackage

[hdl/ictf_cordic.sv]
// iterative cordic vectoring unit: atan2 in 1/256 degree, one rotation per cycle
module ictf_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [ictf_pkg::SAMPLE_W-1:0] opnd_y,
   input  logic signed [ictf_pkg::SAMPLE_W-1:0] opnd_x,
   output logic                               done,
   output logic signed [ictf_pkg::ANGLE_W-1:0]  angle
);

   logic signed [ictf_pkg::XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ictf_pkg::XY_W-1:0] x_load, y_load, x_shift, y_shift;
   logic signed [ictf_pkg::Z_W-1:0]  z_ff, z_in, z_round, z_step;
   logic [ictf_pkg::ITER_W-1:0]      iter_ff, iter_in;
   logic                             busy_ff, busy_in, done_ff, done_in;
   logic                             zero_ff, zero_in;

   always_comb begin
      x_load  = $signed({{(ictf_pkg::XY_W-ictf_pkg::SAMPLE_W-8){opnd_x[ictf_pkg::SAMPLE_W-1]}},
                         opnd_x, 8'h00});
      y_load  = $signed({{(ictf_pkg::XY_W-ictf_pkg::SAMPLE_W-8){opnd_y[ictf_pkg::SAMPLE_W-1]}},
                         opnd_y, 8'h00});
      x_shift = x_ff >>> iter_ff;
      y_shift = y_ff >>> iter_ff;
      z_step  = ictf_pkg::atan_step(5'(iter_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (!busy_ff && start) begin
         busy_in = 1'b1;
         iter_in = '0;
         zero_in = (opnd_x == '0) && (opnd_y == '0);
         if (!opnd_x[ictf_pkg::SAMPLE_W-1]) begin
            x_in = x_load;
            y_in = y_load;
            z_in = '0;
         end else if (!opnd_y[ictf_pkg::SAMPLE_W-1]) begin
            // left half plane: rotate by -90 degrees first
            x_in = y_load;
            y_in = -x_load;
            z_in = ictf_pkg::Z_QUARTER;
         end else begin
            x_in = -y_load;
            y_in = x_load;
            z_in = -ictf_pkg::Z_QUARTER;
         end
      end else if (busy_ff) begin
         if (!y_ff[ictf_pkg::XY_W-1]) begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + z_step;
         end else begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - z_step;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ictf_pkg::ITER_W'(ictf_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      zero_ff <= zero_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // round half up to 1/256 degree
   assign z_round = z_ff + ictf_pkg::Z_HALF_LSB;
   assign angle   = zero_ff ? '0 : $signed(z_round[8 +: ictf_pkg::ANGLE_W]);
   assign done    = done_ff;

endmodule

[hdl/ictf_blend.sv]
// complementary blend on one shared 18x18 multiplier
module ictf_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  ictf_pkg::blend_opnd_type          opnd,
   output logic                              done,
   output logic signed [ictf_pkg::ANGLE_W-1:0] result
);

   ictf_pkg::blend_opnd_type         opnd_ff, opnd_in;
   ictf_pkg::blend_step_type         step_ff, step_in;
   logic                             busy_ff, busy_in, done_ff, done_in;
   logic signed [ictf_pkg::MUL_W-1:0]  mul_a, mul_b, rate, prop;
   logic signed [ictf_pkg::PROD_W-1:0] product, prod_ff, prod_in, prod_round;
   logic signed [ictf_pkg::ACC_W-1:0]  acc_ff, acc_in, acc_sum;
   logic signed [ictf_pkg::SUM_W-1:0]  blended;
   logic signed [ictf_pkg::ANGLE_W-1:0] result_ff, result_in;
   logic [ictf_pkg::WEIGHT_W-1:0]    w_clamp;

   always_comb begin
      w_clamp    = (opnd_ff.weight > ictf_pkg::WEIGHT_ONE) ? ictf_pkg::WEIGHT_ONE
                                                          : opnd_ff.weight;
      prod_round = prod_ff + ictf_pkg::PROD_HALF;
      rate       = $signed(prod_round[16 +: ictf_pkg::MUL_W]);
      prop       = $signed({opnd_ff.est[ictf_pkg::ANGLE_W-1], opnd_ff.est}) + rate;
      acc_sum    = acc_ff + ictf_pkg::ACC_W'(prod_ff) + ictf_pkg::ACC_HALF;
      blended    = $signed(acc_sum[16 +: ictf_pkg::SUM_W]);
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (!busy_ff) begin
         mul_a = ictf_pkg::MUL_W'(opnd.gyro);
         mul_b = $signed({2'b00, opnd.gain});
      end else begin
         case (step_ff)
            ictf_pkg::BL_PROP: begin
               mul_a = $signed({1'b0, w_clamp});
               mul_b = prop;
            end
            ictf_pkg::BL_ACCEL: begin
               mul_a = $signed({1'b0, ictf_pkg::WEIGHT_ONE - w_clamp});
               mul_b = ictf_pkg::MUL_W'(opnd_ff.accel);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
      product = mul_a * mul_b;
   end

   always_comb begin
      opnd_in   = opnd_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            opnd_in = opnd;
            prod_in = product;
            step_in = ictf_pkg::BL_PROP;
            busy_in = 1'b1;
         end
      end else begin
         unique case (step_ff)
            ictf_pkg::BL_PROP: begin
               prod_in = product;
               step_in = ictf_pkg::BL_ACCEL;
            end
            ictf_pkg::BL_ACCEL: begin
               acc_in  = ictf_pkg::ACC_W'(prod_ff);
               prod_in = product;
               step_in = ictf_pkg::BL_SUM;
            end
            ictf_pkg::BL_SUM: begin
               if (blended > ictf_pkg::EST_MAX) begin
                  result_in = ictf_pkg::ANGLE_W'(ictf_pkg::EST_MAX);
               end else if (blended < ictf_pkg::EST_MIN) begin
                  result_in = ictf_pkg::ANGLE_W'(ictf_pkg::EST_MIN);
               end else begin
                  result_in = ictf_pkg::ANGLE_W'(blended);
               end
               done_in = 1'b1;
               busy_in = 1'b0;
               step_in = ictf_pkg::BL_RATE;
            end
            ictf_pkg::BL_RATE: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff   <= opnd_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
      if (reset) begin
         step_ff <= ictf_pkg::BL_RATE;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[hdl/imu_complementary_tilt_filter.sv]
// roll/pitch complementary tilt filter: sequencer, registers and stream ports
// each sample runs roll atan, pitch atan, roll blend, pitch blend, then its result beat
// a new sample is taken only in idle, after the result is loaded: the shared cordic
//    unit runs roll then pitch, followed by two blends on one multiplier
// reset: estimates cleared to zero, blend_weight 64225, gyro_gain 1280, no result pending
module imu_complementary_tilt_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y
   input  logic [79:0]                         req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // roll_angle, pitch_angle, zero pad
   output logic [39:0]                         rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ictf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   ictf_pkg::tilt_state_type state_ff, state_in;

   logic [ictf_pkg::WEIGHT_W-1:0]       weight_ff;
   logic [ictf_pkg::GAIN_W-1:0]         gain_ff;
   logic signed [ictf_pkg::SAMPLE_W-1:0] ax_ff, az_ff, gx_ff, gy_ff;
   logic signed [ictf_pkg::ANGLE_W-1:0]  roll_ang_ff, pitch_ang_ff;
   logic signed [ictf_pkg::ANGLE_W-1:0]  roll_est_ff, pitch_est_ff;
   logic signed [ictf_pkg::ANGLE_W-1:0]  rsp_roll_ff, rsp_pitch_ff;
   logic                                 rsp_valid_ff;

   logic                                 req_beat, csr_write, out_free, load_out;
   logic                                 cordic_start, cordic_done;
   logic signed [ictf_pkg::SAMPLE_W-1:0] cordic_y, cordic_x;
   logic signed [ictf_pkg::ANGLE_W-1:0]  cordic_angle;
   logic                                 blend_start, blend_done;
   logic signed [ictf_pkg::ANGLE_W-1:0]  blend_result;
   ictf_pkg::blend_opnd_type             blend_opnd;

   assign req_beat   = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_pready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ictf_pkg::ST_IDLE:        if (req_tvalid)  state_in = ictf_pkg::ST_ROLL_ATAN;
         ictf_pkg::ST_ROLL_ATAN:   if (cordic_done) state_in = ictf_pkg::ST_PITCH_ATAN;
         ictf_pkg::ST_PITCH_ATAN:  if (cordic_done) state_in = ictf_pkg::ST_ROLL_BLEND;
         ictf_pkg::ST_ROLL_BLEND:  if (blend_done)  state_in = ictf_pkg::ST_PITCH_BLEND;
         ictf_pkg::ST_PITCH_BLEND: if (blend_done)  state_in = ictf_pkg::ST_DELIVER;
         ictf_pkg::ST_DELIVER:     if (out_free)    state_in = ictf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready   = 1'b0;
      cordic_start = 1'b0;
      blend_start  = 1'b0;
      load_out     = 1'b0;
      unique case (state_ff)
         ictf_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cordic_start = req_tvalid;
         end
         ictf_pkg::ST_ROLL_ATAN:   cordic_start = cordic_done;
         ictf_pkg::ST_PITCH_ATAN:  blend_start  = cordic_done;
         ictf_pkg::ST_ROLL_BLEND:  blend_start  = blend_done;
         ictf_pkg::ST_PITCH_BLEND: blend_start  = 1'b0;
         ictf_pkg::ST_DELIVER:     load_out     = out_free;
      endcase
   end

   // roll takes y and z straight from the beat, pitch uses the stored x and z
   always_comb begin
      if (state_ff == ictf_pkg::ST_IDLE) begin
         cordic_y = $signed(req_tdata[31:16]);
         cordic_x = $signed(req_tdata[47:32]);
      end else begin
         cordic_y = ax_ff;
         cordic_x = az_ff;
      end
      blend_opnd.weight = weight_ff;
      blend_opnd.gain   = gain_ff;
      if (state_ff == ictf_pkg::ST_PITCH_ATAN) begin
         blend_opnd.est   = roll_est_ff;
         blend_opnd.gyro  = gx_ff;
         blend_opnd.accel = roll_ang_ff;
      end else begin
         blend_opnd.est   = pitch_est_ff;
         blend_opnd.gyro  = gy_ff;
         blend_opnd.accel = pitch_ang_ff;
      end
   end

   ictf_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .opnd_y (cordic_y),
      .opnd_x (cordic_x),
      .done   (cordic_done),
      .angle  (cordic_angle)
   );

   ictf_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .start  (blend_start),
      .opnd   (blend_opnd),
      .done   (blend_done),
      .result (blend_result)
   );

   always_ff @(posedge clock) begin
      if (req_beat) begin
         ax_ff <= $signed(req_tdata[15:0]);
         az_ff <= $signed(req_tdata[47:32]);
         gx_ff <= $signed(req_tdata[63:48]);
         gy_ff <= $signed(req_tdata[79:64]);
      end
      if (state_ff == ictf_pkg::ST_ROLL_ATAN && cordic_done) begin
         roll_ang_ff <= cordic_angle;
      end
      if (state_ff == ictf_pkg::ST_PITCH_ATAN && cordic_done) begin
         pitch_ang_ff <= cordic_angle;
      end
      if (load_out) begin
         rsp_roll_ff  <= roll_est_ff;
         rsp_pitch_ff <= pitch_est_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ictf_pkg::ST_IDLE;
         weight_ff    <= ictf_pkg::WEIGHT_RESET;
         gain_ff      <= ictf_pkg::GAIN_RESET;
         roll_est_ff  <= '0;
         pitch_est_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_paddr[2])
               ictf_pkg::REG_BLEND_WEIGHT: weight_ff <= csr_pwdata[ictf_pkg::WEIGHT_W-1:0];
               ictf_pkg::REG_GYRO_GAIN:    gain_ff   <= csr_pwdata[ictf_pkg::GAIN_W-1:0];
            endcase
         end
         if (state_ff == ictf_pkg::ST_ROLL_BLEND && blend_done) begin
            roll_est_ff <= blend_result;
         end
         if (state_ff == ictf_pkg::ST_PITCH_BLEND && blend_done) begin
            pitch_est_ff <= blend_result;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         ictf_pkg::REG_BLEND_WEIGHT: csr_prdata = 32'(weight_ff);
         ictf_pkg::REG_GYRO_GAIN:    csr_prdata = 32'(gain_ff);
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_pitch_ff, rsp_roll_ff};

   a_beat_starts_roll: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ictf_pkg::ST_ROLL_ATAN))
      else $error("input beat did not start the roll angle");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cordic_done && blend_done))
      else $error("cordic and blend finished together");

   a_deliver_result: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (rsp_tvalid && state_ff == ictf_pkg::ST_IDLE))
      else $error("finished sample not presented");

   a_blend_from_atan: assert property (@(posedge clock) disable iff (reset)
      blend_start |-> (state_ff == ictf_pkg::ST_PITCH_ATAN ||
                       state_ff == ictf_pkg::ST_ROLL_BLEND))
      else $error("blend started outside its slot");

endmodule
